[design/assert_macros.svh]
// assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, ignored while reset is asserted (active low).
`define TDPT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds across reset.
`define TDPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int CAND_W      = 32;
    localparam int DATA_W      = (VALUE_WIDTH < CAND_W) ? VALUE_WIDTH : CAND_W;
    localparam int CNT_W       = $clog2(DATA_W);

    typedef logic [CAND_W-1:0] cand_t;
    typedef logic [DATA_W-1:0] data_t;

    localparam data_t TWO           = data_t'(2);
    localparam data_t FIRST_ODD_DIV = data_t'(3);
    localparam data_t DIV_STEP      = data_t'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RUN,
        ST_FINISH
    } state_t;

    // divider -> sequencer status
    typedef struct packed {
        logic  done;
        data_t quot;
        data_t rem;
    } div_result_t;

endpackage

[design/tdpt_div.sv]
// ----------------------------------------------------------------------------
// tdpt_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  tdpt_pkg::data_t       dividend,
    input  tdpt_pkg::data_t       divisor,
    output tdpt_pkg::div_result_t result
);
    import tdpt_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    data_t              quo_reg, quo_next;   // dividend bits out, quotient bits in
    data_t              rem_reg, rem_next;
    data_t              dsr_reg, dsr_next;

    logic [DATA_W:0]    shifted;
    logic [DATA_W:0]    diff;
    logic               fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[DATA_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = ~diff[DATA_W];
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DATA_W-2:0], fits};
            rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign result.done = done_reg;
    assign result.quot = quo_reg;
    assign result.rem  = rem_reg;

endmodule

[design/trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Answers whether an unsigned candidate is prime by trial division.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_candidate carries one request per
//   candidate; the result channel m_valid/m_ready/m_is_prime returns one bit.
//   One request is worked on at a time: s_ready is high only when idle.
//   An accepted request goes to the check state. 0, 1 and even numbers
//   are decided there; the verdict then passes through the finish state
//   into the output register. Odd candidates run divisors 3, 5, 7, ...
//   through a bit-serial divider until a divisor divides the candidate or
//   exceeds the quotient. A prime near 2^32 tries about 32768 divisors.
//   The divider's one-bit-per-cycle shift loop sets the rate.
//   The result sits in an output register, so the next request is taken
//   while the previous answer still waits for m_ready. If the receiver
//   stalls with a result pending, a finished test waits in the finish
//   state until the register frees up.
//   Reset (aresetn low, synchronous) returns to idle and drops m_valid.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tdpt_pkg::cand_t s_candidate,
    output logic            m_valid,
    input  logic            m_ready,
    output logic            m_is_prime
);
    import tdpt_pkg::*;

    state_t      state_reg, state_next;
    data_t       n_reg, n_next;          // candidate under test
    data_t       d_reg, d_next;          // current trial divisor
    logic        res_reg, res_next;      // verdict waiting for the output register
    logic        m_valid_reg, m_valid_next;
    logic        m_prime_reg, m_prime_next;

    div_result_t div_res;
    logic        div_start;
    data_t       div_divisor;

    // control decoded from state
    logic        accept;
    logic        check_done, check_res;
    logic        run_stop, run_zero, run_done;
    logic        out_load;

    tdpt_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (n_reg),
        .divisor  (div_divisor),
        .result   (div_res)
    );

    // output / control decode
    always_comb begin
        s_ready     = (state_reg == ST_IDLE);
        accept      = s_valid && s_ready;
        // 0 and 1 and even numbers need no division; only 2 is prime
        check_done  = (n_reg[DATA_W-1:1] == '0) || !n_reg[0];
        check_res   = (n_reg == TWO);
        // divisor past the quotient means its square exceeds the candidate
        run_stop    = (d_reg > div_res.quot);
        run_zero    = (div_res.rem == '0);
        run_done    = div_res.done && (run_stop || run_zero);
        div_start   = ((state_reg == ST_CHECK) && !check_done) ||
                      ((state_reg == ST_RUN) && div_res.done && !run_stop && !run_zero);
        div_divisor = (state_reg == ST_CHECK) ? FIRST_ODD_DIV : data_t'(d_reg + DIV_STEP);
        out_load    = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) begin
                state_next = ST_CHECK;
            end
            ST_CHECK:  state_next = check_done ? ST_FINISH : ST_RUN;
            ST_RUN:    if (run_done) begin
                state_next = ST_FINISH;
            end
            ST_FINISH: if (out_load) begin
                state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_next       = accept ? s_candidate[DATA_W-1:0] : n_reg;
        d_next       = div_start ? div_divisor : d_reg;
        res_next     = res_reg;
        if ((state_reg == ST_CHECK) && check_done) begin
            res_next = check_res;
        end else if ((state_reg == ST_RUN) && div_res.done) begin
            res_next = run_stop;
        end
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
        m_prime_next = out_load ? res_reg : m_prime_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        res_reg     <= res_next;
        m_prime_reg <= m_prime_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_prime_reg;

endmodule

[design/tdpt_checker.sv]
// ----------------------------------------------------------------------------
// tdpt_checker
// Port-level assertions for trial_division_prime_test, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdpt_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_is_prime
);

    // stalled result holds
    `TDPT_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_is_prime), "result changed while stalled")

    // one request in flight: input closes right after an accept
    `TDPT_ASSERT(a_one_inflight, aclk, aresetn, s_valid && s_ready |=> !s_ready, "second request taken while busy")

    // a new result only appears from a running test, never straight from idle
    `TDPT_ASSERT(a_result_from_run, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready), "result appeared without a running test")

    // reset drops the result channel
    `TDPT_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_valid, "m_valid high after reset")

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_is_prime (m_is_prime)
);

[tb/trial_division_prime_test_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trial_division_prime_test_tb
// Drives candidates into the prime tester and checks every answer against
// a behavioral trial-division predictor, with random stalls on both channels.
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;

    import tdpt_pkg::*;

    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 116;
    localparam int TAIL_ITEMS     = 25;      // last stretch runs without idling
    localparam int DRAIN_CYCLES   = 100;     // settle time after the last answer
    // Worst single requests here are 1021^2 and the prime 1048573: ~510 divisors each.
    localparam int WATCHDOG_LIMIT = 100000;

    typedef struct {
        cand_t cand;
        bit    hold_until_idle;   // sender waits for all answers before this one
    } cand_req_t;

    logic  aclk        = 1'b0;
    logic  aresetn     = 1'b0;
    logic  s_valid     = 1'b0;
    logic  s_ready;
    cand_t s_candidate = '0;
    logic  m_valid;
    logic  m_ready     = 1'b0;
    logic  m_is_prime;

    // Requests waiting to be sent, and answers still owed by the block.
    cand_req_t pending_reqs[$];
    bit        prime_flags_due[$];

    cand_req_t next_req;
    int        send_gap_left  = 0;
    int        stall_left     = 0;
    bit        tail_phase     = 1'b0;
    bit        expected_flag;
    int        mismatches     = 0;
    int        quiet_cycles   = 0;

    // Edge values: 0/1/2, small primes and composites, prime squares that sit
    // right on the divisor-squared bound, and wide values with small factors.
    cand_t directed_cands[] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25,
        32'd49, 32'd97, 32'd121, 32'd1009, 32'd63001, 32'd65521, 32'd65537,
        32'd1042441, 32'd1048573, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
        32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA, 32'h5555_5555
    };

    trial_division_prime_test dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_candidate (s_candidate),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_is_prime  (m_is_prime)
    );

    always #1 aclk = ~aclk;

    // Primality by trial division: 2, then odd divisors while d*d <= n.
    // Only the low DATA_W bits of the candidate count.
    function automatic bit prime_by_trial(cand_t raw);
        longint unsigned n;
        longint unsigned d;
        n = longint'(data_t'(raw));
        if (n < 2)
            return 1'b0;
        if (n % 2 == 0)
            return n == 2;
        for (d = 3; d <= n / d; d += 2)
            if (n % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    // Random candidates: mostly short tests, plus full-width values forced
    // onto a small factor so the high bits toggle without huge run times.
    function automatic cand_t random_candidate();
        cand_t v;
        int    pick;
        int    fac;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            v = $urandom_range(0, 4095);
        end else if (pick < 7) begin
            v = $urandom_range(4096, 65535);
        end else if (pick < 9) begin
            case ($urandom_range(0, 4))
                0: fac = 3;
                1: fac = 5;
                2: fac = 7;
                3: fac = 11;
                default: fac = 13;
            endcase
            v = $urandom;
            v = v - (v % fac);
        end else begin
            v = $urandom;
            v[0] = 1'b0;
        end
        return v;
    endfunction

    // Driver: loads the next request whenever the input register is free,
    // inserting random idle bursts outside the tail of the run.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_candidate   <= '0;
            send_gap_left = 0;
            tail_phase    <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                prime_flags_due.push_back(prime_by_trial(s_candidate));
            if (!s_valid || s_ready) begin
                if (send_gap_left > 0) begin
                    send_gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_reqs.size() == 0 ||
                             (pending_reqs[0].hold_until_idle &&
                              prime_flags_due.size() != 0)) begin
                    s_valid <= 1'b0;
                end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
                    send_gap_left = $urandom_range(1, 10) - 1;
                    s_valid <= 1'b0;
                end else begin
                    next_req = pending_reqs.pop_front();
                    s_candidate <= next_req.cand;
                    s_valid     <= 1'b1;
                end
            end
            tail_phase <= (pending_reqs.size() < TAIL_ITEMS);
        end
    end

    // Monitor: checks each answer against the oldest prediction and
    // throttles m_ready with random stall bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (prime_flags_due.size() == 0) begin
                    $display("%0t ns: unexpected result: expected none, actual is_prime=%0b",
                             $time, m_is_prime);
                    mismatches++;
                end else begin
                    expected_flag = prime_flags_due.pop_front();
                    if (m_is_prime !== expected_flag) begin
                        $display("%0t ns: is_prime mismatch: expected %0b, actual %0b",
                                 $time, expected_flag, m_is_prime);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a long stretch without any handshake means the block hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        cand_req_t req;
        int        i;

        foreach (directed_cands[k]) begin
            req.cand            = directed_cands[k];
            req.hold_until_idle = 1'b0;
            pending_reqs.push_back(req);
        end
        // Random part; the sender drains the block completely twice on the way.
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            req.cand            = random_candidate();
            req.hold_until_idle = (i == 0) || (i == RANDOM_ITEMS / 2);
            pending_reqs.push_back(req);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid || prime_flags_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/tdpt_pkg.sv
design/tdpt_div.sv
design/trial_division_prime_test.sv
design/tdpt_checker.sv
tb/trial_division_prime_test_tb.sv
